### hw/rtl/dequ_pkg.sv
// Shared types and codes for the double-ended queue unit.
package dequ_pkg;

   localparam int unsigned OCC_WIDTH    = 5;
   localparam int unsigned RESULT_WIDTH = 32;

   typedef enum logic [1:0] {
      OP_PUSH_FRONT = 2'd0,
      OP_PUSH_BACK  = 2'd1,
      OP_POP_FRONT  = 2'd2,
      OP_POP_BACK   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic shift_right;
      logic shift_left;
      logic push_back;
   } dequ_ctrl_type;

endpackage

### hw/rtl/dequ_cell.sv
// One storage cell of the deque chain: holds one entry, trades with its neighbors.
module dequ_cell #(
   parameter int unsigned DATA_WIDTH = 32,
   parameter int unsigned COUNT_W    = 5,
   parameter int unsigned CELL_INDEX = 0
) (
   input  logic                   clock,
   input  dequ_pkg::dequ_ctrl_type ctrl,
   input  logic [COUNT_W-1:0]     occ,
   input  logic [DATA_WIDTH-1:0]  push_data,
   input  logic [DATA_WIDTH-1:0]  left_data,
   input  logic [DATA_WIDTH-1:0]  right_data,
   output logic [DATA_WIDTH-1:0]  cell_data,
   output logic [DATA_WIDTH-1:0]  tail_tap
);

   logic [DATA_WIDTH-1:0] val_ff;
   logic [DATA_WIDTH-1:0] val_in;

   always_comb begin
      val_in = val_ff;
      if (ctrl.shift_right) begin
         val_in = left_data;
      end else if (ctrl.shift_left) begin
         val_in = right_data;
      end else if (ctrl.push_back && (occ == COUNT_W'(CELL_INDEX))) begin
         val_in = push_data;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

   assign cell_data = val_ff;
   assign tail_tap  = (occ == COUNT_W'(CELL_INDEX + 1)) ? val_ff : '0;

endmodule

### hw/rtl/double_ended_queue_unit.sv
// Top level of the fixed-capacity double-ended queue unit.
// The queue is a row of DEPTH cells kept packed from cell 0, which always
// holds the front entry; push front and pop front shift the whole row one
// cell, push back writes the cell just past the tail, pop back reads the
// tail cell. One operation is taken per clock: busy stays low, and every
// beat accepted on start yields exactly one result beat, marked by
// rsp_strobe, in the cycle right after. The receiver cannot stall, so the
// result must be captured in that single cycle. A push onto a full queue
// reports status 1 and leaves the contents alone; a pop from an empty queue
// reports status 2 and returns 0.
module double_ended_queue_unit #(
   parameter int unsigned DEPTH      = 16,
   parameter int unsigned DATA_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [1:0]                           req_opcode,
   input  logic signed [31:0]                   req_push_value,
   output logic                                 rsp_strobe,
   output logic signed [dequ_pkg::RESULT_WIDTH-1:0] rsp_popped_value,
   output logic [1:0]                           rsp_status,
   output logic [dequ_pkg::OCC_WIDTH-1:0]       rsp_occupancy_out
);

   localparam int unsigned COUNT_W = $clog2(DEPTH + 1);

   logic [COUNT_W-1:0]    occ_ff;
   logic [COUNT_W-1:0]    occ_in;
   logic                  strobe_ff;
   logic [DATA_WIDTH-1:0] popped_ff;
   logic [DATA_WIDTH-1:0] popped_in;
   logic [1:0]            status_ff;
   logic [1:0]            status_in;

   dequ_pkg::dequ_ctrl_type ctrl;
   dequ_pkg::opcode_type    op;

   logic [DATA_WIDTH-1:0] push_data;
   logic [DATA_WIDTH-1:0] cell_q   [DEPTH];
   logic [DATA_WIDTH-1:0] tail_q   [DEPTH];
   logic [DATA_WIDTH-1:0] left_d   [DEPTH];
   logic [DATA_WIDTH-1:0] right_d  [DEPTH];
   logic [DATA_WIDTH-1:0] tail_val;
   logic                  full;
   logic                  empty;

   logic [DATA_WIDTH+31:0]                 push_ext;
   logic [DATA_WIDTH+31:0]                 pop_ext;
   logic [COUNT_W+dequ_pkg::OCC_WIDTH-1:0] occ_ext;

   assign push_ext  = {{DATA_WIDTH{1'b0}}, req_push_value};
   assign push_data = push_ext[DATA_WIDTH-1:0];
   assign op        = dequ_pkg::opcode_type'(req_opcode);
   assign full      = (occ_ff == COUNT_W'(DEPTH));
   assign empty     = (occ_ff == '0);

   always_comb begin
      tail_val = '0;
      for (int i = 0; i < DEPTH; i++) begin
         tail_val = tail_val | tail_q[i];
      end
   end

   always_comb begin
      ctrl      = '0;
      occ_in    = occ_ff;
      popped_in = '0;
      status_in = dequ_pkg::ST_DONE;
      if (start) begin
         unique case (op)
            dequ_pkg::OP_PUSH_FRONT: begin
               if (full) begin
                  status_in = dequ_pkg::ST_FULL;
               end else begin
                  ctrl.shift_right = 1'b1;
                  occ_in           = occ_ff + COUNT_W'(1);
               end
            end
            dequ_pkg::OP_PUSH_BACK: begin
               if (full) begin
                  status_in = dequ_pkg::ST_FULL;
               end else begin
                  ctrl.push_back = 1'b1;
                  occ_in         = occ_ff + COUNT_W'(1);
               end
            end
            dequ_pkg::OP_POP_FRONT: begin
               if (empty) begin
                  status_in = dequ_pkg::ST_EMPTY;
               end else begin
                  ctrl.shift_left = 1'b1;
                  popped_in       = cell_q[0];
                  occ_in          = occ_ff - COUNT_W'(1);
               end
            end
            dequ_pkg::OP_POP_BACK: begin
               if (empty) begin
                  status_in = dequ_pkg::ST_EMPTY;
               end else begin
                  popped_in = tail_val;
                  occ_in    = occ_ff - COUNT_W'(1);
               end
            end
            default: begin
               status_in = dequ_pkg::ST_DONE;
            end
         endcase
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign left_d[i] = push_data;
      end else begin : g_mid
         assign left_d[i] = cell_q[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_d[i] = cell_q[i];
      end else begin : g_body
         assign right_d[i] = cell_q[i+1];
      end

      dequ_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .COUNT_W    (COUNT_W),
         .CELL_INDEX (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .occ        (occ_ff),
         .push_data  (push_data),
         .left_data  (left_d[i]),
         .right_data (right_d[i]),
         .cell_data  (cell_q[i]),
         .tail_tap   (tail_q[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         occ_ff    <= occ_in;
         strobe_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      popped_ff <= popped_in;
      status_ff <= status_in;
   end

   assign pop_ext           = {32'd0, popped_ff};
   assign occ_ext           = {{dequ_pkg::OCC_WIDTH{1'b0}}, occ_ff};
   assign busy              = 1'b0;
   assign rsp_strobe        = strobe_ff;
   assign rsp_popped_value  = pop_ext[dequ_pkg::RESULT_WIDTH-1:0];
   assign rsp_status        = status_ff;
   assign rsp_occupancy_out = occ_ext[dequ_pkg::OCC_WIDTH-1:0];

endmodule

### tb/double_ended_queue_unit_test.sv
// Self-checking testbench for the double-ended queue unit: directed and random beats.
module double_ended_queue_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned DEPTH = 16;
   localparam int unsigned RANDOM_BEATS = 1200;

   typedef struct {
      logic signed [31:0]             popped;
      dequ_pkg::status_type           status;
      logic [dequ_pkg::OCC_WIDTH-1:0] occupancy;
   } reply_type;

   class deque_scoreboard;
      logic signed [31:0]             contents [DEPTH];
      logic [3:0]                     head = '0;
      logic [dequ_pkg::OCC_WIDTH-1:0] count = '0;
      reply_type                      reply_queue [$];
      int unsigned                    mismatches = 0;
      int unsigned                    pushes = 0;
      int unsigned                    pops = 0;
      int unsigned                    full_rejects = 0;
      int unsigned                    empty_rejects = 0;
      int unsigned                    peak = 0;

      function void note_request(dequ_pkg::opcode_type op, logic signed [31:0] value);
         reply_type r;
         logic [3:0] slot;
         r.popped = '0;
         r.status = dequ_pkg::ST_DONE;
         if (op == dequ_pkg::OP_PUSH_FRONT || op == dequ_pkg::OP_PUSH_BACK) begin
            if (count == DEPTH) begin
               r.status = dequ_pkg::ST_FULL;
               full_rejects++;
            end else begin
               if (op == dequ_pkg::OP_PUSH_FRONT) begin
                  head = head - 4'd1;
                  slot = head;
               end else begin
                  slot = head + count[3:0];
               end
               contents[slot] = value;
               count++;
               pushes++;
            end
         end else begin
            if (count == 0) begin
               r.status = dequ_pkg::ST_EMPTY;
               empty_rejects++;
            end else begin
               if (op == dequ_pkg::OP_POP_FRONT) begin
                  r.popped = contents[head];
                  head = head + 4'd1;
               end else begin
                  slot = head + count[3:0] - 4'd1;
                  r.popped = contents[slot];
               end
               count--;
               pops++;
            end
         end
         r.occupancy = count;
         if (count > peak) peak = count;
         reply_queue.push_back(r);
      endfunction

      function void check_reply(logic signed [31:0] popped, logic [1:0] status,
                                logic [dequ_pkg::OCC_WIDTH-1:0] occupancy);
         reply_type e;
         if (reply_queue.size() == 0) begin
            $error("reply beat with no request outstanding");
            mismatches++;
            return;
         end
         e = reply_queue.pop_front();
         if (popped !== e.popped) begin
            $error("rsp_popped_value: expected %0d, actual %0d", e.popped, popped);
            mismatches++;
         end
         if (status !== e.status) begin
            $error("rsp_status: expected %0d, actual %0d", e.status, status);
            mismatches++;
         end
         if (occupancy !== e.occupancy) begin
            $error("rsp_occupancy_out: expected %0d, actual %0d", e.occupancy, occupancy);
            mismatches++;
         end
      endfunction

      function int unsigned outstanding();
         return reply_queue.size();
      endfunction
   endclass

   logic                                 clock;
   logic                                 reset;
   logic                                 start;
   logic                                 busy;
   logic [1:0]                           req_opcode;
   logic signed [31:0]                   req_push_value;
   logic                                 rsp_strobe;
   logic signed [dequ_pkg::RESULT_WIDTH-1:0] rsp_popped_value;
   logic [1:0]                           rsp_status;
   logic [dequ_pkg::OCC_WIDTH-1:0]       rsp_occupancy_out;

   deque_scoreboard sb = new;

   double_ended_queue_unit dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_push_value    (req_push_value),
      .rsp_strobe        (rsp_strobe),
      .rsp_popped_value  (rsp_popped_value),
      .rsp_status        (rsp_status),
      .rsp_occupancy_out (rsp_occupancy_out)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("Verification failed");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe === 1'b1) begin
            sb.check_reply(rsp_popped_value, rsp_status, rsp_occupancy_out);
         end else if (rsp_strobe !== 1'b0) begin
            $error("rsp_strobe: expected 0 or 1, actual %b", rsp_strobe);
            sb.mismatches++;
         end
         if (start && !busy) begin
            sb.note_request(dequ_pkg::opcode_type'(req_opcode), req_push_value);
         end
      end
   end

   task automatic issue(dequ_pkg::opcode_type op, logic signed [31:0] value);
      start          <= 1'b1;
      req_opcode     <= op;
      req_push_value <= value;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic hold_off(int unsigned cycles);
      if (cycles == 0) return;
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // hold until every reply beat has come back
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
   endtask

   function automatic int unsigned pick_gap(bit steady);
      int unsigned r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'sd0;
         1: return -32'sd1;
         2: return 32'sh7fffffff;
         3: return 32'sh80000000;
         4: return $urandom_range(0, 15);
         default: return $urandom;
      endcase
   endfunction

   function automatic dequ_pkg::opcode_type pick_op(int unsigned push_bias);
      if ($urandom_range(0, 99) < push_bias)
         return $urandom_range(0, 1) ? dequ_pkg::OP_PUSH_BACK : dequ_pkg::OP_PUSH_FRONT;
      return $urandom_range(0, 1) ? dequ_pkg::OP_POP_BACK : dequ_pkg::OP_POP_FRONT;
   endfunction

   initial begin
      int unsigned biases [5] = '{95, 75, 50, 25, 5};
      int unsigned sent;
      int unsigned span;
      int unsigned bias;
      bit steady;

      reset          <= 1'b1;
      start          <= 1'b0;
      req_opcode     <= dequ_pkg::OP_PUSH_FRONT;
      req_push_value <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      issue(dequ_pkg::OP_POP_FRONT, 32'sh12345678);
      issue(dequ_pkg::OP_POP_BACK, -32'sd1);
      issue(dequ_pkg::OP_PUSH_FRONT, 32'sd0);
      issue(dequ_pkg::OP_PUSH_BACK, -32'sd1);
      issue(dequ_pkg::OP_POP_BACK, 32'sd0);
      issue(dequ_pkg::OP_POP_FRONT, 32'sd0);
      for (int i = 0; i < DEPTH; i++) begin
         case (i % 4)
            0: issue(dequ_pkg::OP_PUSH_FRONT, 32'sh7fffffff);
            1: issue(dequ_pkg::OP_PUSH_BACK, 32'sh80000000);
            2: issue(dequ_pkg::OP_PUSH_FRONT, 32'sd0);
            default: issue(dequ_pkg::OP_PUSH_BACK, $urandom);
         endcase
      end
      issue(dequ_pkg::OP_PUSH_FRONT, 32'sh55555555);
      issue(dequ_pkg::OP_PUSH_BACK, 32'shaaaaaaaa);
      issue(dequ_pkg::OP_POP_BACK, 32'sd0);
      drain();

      sent = 0;
      while (sent < RANDOM_BEATS) begin
         bias   = biases[$urandom_range(0, 4)];
         steady = ($urandom_range(0, 3) == 0);
         span   = $urandom_range(20, 80);
         for (int i = 0; i < span && sent < RANDOM_BEATS; i++) begin
            issue(pick_op(bias), pick_value());
            sent++;
            hold_off(pick_gap(steady));
         end
         if ($urandom_range(0, 4) == 0) drain();
      end

      drain();
      repeat (5) @(posedge clock);

      $display("Ran %0d pushes and %0d pops; refused %0d pushes as full, %0d pops as empty",
               sb.pushes, sb.pops, sb.full_rejects, sb.empty_rejects);
      $display("Occupancy peaked at %0d of %0d entries; %0d mismatches found",
               sb.peak, DEPTH, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
